/* hdl/assert_macros.svh */
// assertion macros shared by the velocity pid rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define VPID_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define VPID_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/vpid_pkg.sv */
// shared types, codes and saturation helper for the velocity pid
`timescale 1ns / 1ps

package vpid_pkg;

   // data and gain widths
   localparam int DATA_W  = 16;
   localparam int GAIN_W  = 16;
   localparam int FUNC_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int ACC_W   = 32;
   localparam int SHIFT_W = 8;
   localparam int INC_W   = ACC_W - SHIFT_W;
   localparam int SUM_W   = INC_W + 1;

   // step codes (the unused code behaves as a sample step)
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INVALID = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV = 2'd2;

   // saturation limits
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // difference terms handed from the difference stage to the mac stage
   typedef struct packed {
      logic signed [DATA_W-1:0] error;
      logic signed [DATA_W-1:0] slope;
      logic signed [DATA_W-1:0] curve;
      logic signed [DATA_W-1:0] restart_error;
   } terms_type;

   // saturating subtraction a - b
   function automatic logic signed [DATA_W-1:0] sat_sub(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b
   );
      logic [DATA_W:0] diff;
      logic signed [DATA_W-1:0] res;
      diff = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (diff[DATA_W] != diff[DATA_W-1]) begin
         res = diff[DATA_W] ? DATA_MIN : DATA_MAX;
      end else begin
         res = diff[DATA_W-1:0];
      end
      return res;
   endfunction

endpackage

/* hdl/vpid_diff.sv */
// error, first and second difference terms of one step
`timescale 1ns / 1ps

module vpid_diff (
   input  logic [vpid_pkg::FUNC_W-1:0]        func,
   input  logic signed [vpid_pkg::DATA_W-1:0] measure,
   input  logic signed [vpid_pkg::DATA_W-1:0] last_error,
   input  logic signed [vpid_pkg::DATA_W-1:0] last_slope,
   output vpid_pkg::terms_type                terms
);

   logic signed [vpid_pkg::DATA_W-1:0] meas_eff;

   // an invalid sample reuses the negated previous error, wrapped
   always_comb begin
      if (func == vpid_pkg::FUNC_INVALID) begin
         meas_eff = '0 - last_error;
      end else begin
         meas_eff = measure;
      end
   end

   // saturating difference chain, and the wrapped restart error
   always_comb begin
      terms.error         = vpid_pkg::sat_sub('0, meas_eff);
      terms.slope         = vpid_pkg::sat_sub(terms.error, last_error);
      terms.curve         = vpid_pkg::sat_sub(terms.slope, last_slope);
      terms.restart_error = '0 - measure;
   end

endmodule

/* hdl/vpid_mac.sv */
// gain products, wrapped sum, scaling and clamped accumulation
`timescale 1ns / 1ps

module vpid_mac (
   input  logic signed [vpid_pkg::GAIN_W-1:0] gain_prop,
   input  logic signed [vpid_pkg::GAIN_W-1:0] gain_integ,
   input  logic signed [vpid_pkg::GAIN_W-1:0] gain_deriv,
   input  vpid_pkg::terms_type                terms,
   input  logic signed [vpid_pkg::DATA_W-1:0] last_drive,
   output logic signed [vpid_pkg::DATA_W-1:0] drive
);

   logic signed [vpid_pkg::ACC_W-1:0] prod_p;
   logic signed [vpid_pkg::ACC_W-1:0] prod_i;
   logic signed [vpid_pkg::ACC_W-1:0] prod_d;
   logic signed [vpid_pkg::ACC_W-1:0] acc;
   logic signed [vpid_pkg::INC_W-1:0] inc;
   logic [vpid_pkg::SUM_W-1:0]        sum;

   // three q10.22 products of q8.8 gains and q2.14 terms, summed modulo 2^32
   always_comb begin
      prod_p = gain_prop  * terms.slope;
      prod_i = gain_integ * terms.error;
      prod_d = gain_deriv * terms.curve;
      acc    = prod_p + prod_i + prod_d;
      inc    = acc[vpid_pkg::ACC_W-1:vpid_pkg::SHIFT_W];
   end

   // add to previous drive and clamp to 16 bits
   always_comb begin
      sum = {{(vpid_pkg::SUM_W-vpid_pkg::DATA_W){last_drive[vpid_pkg::DATA_W-1]}},
             last_drive}
          + {inc[vpid_pkg::INC_W-1], inc};
      if (sum[vpid_pkg::SUM_W-1:vpid_pkg::DATA_W-1] != '0 &&
          sum[vpid_pkg::SUM_W-1:vpid_pkg::DATA_W-1] != '1) begin
         drive = sum[vpid_pkg::SUM_W-1] ? vpid_pkg::DATA_MIN : vpid_pkg::DATA_MAX;
      end else begin
         drive = sum[vpid_pkg::DATA_W-1:0];
      end
   end

endmodule

/* hdl/velocity_pid_q2_14.sv */
// velocity-form pid controller, top level with registers and flow control
// path: input register, then result register (rsp_); the compute stage lies between
// throughput: one item per cycle unless rsp_ stalls; the state loop (differences,
//   three products, sum and clamp) closes within the single compute stage
// stall: req_stall is high only while both registers hold items and rsp_ is stalled
// reset: synchronous; clears the gains, the step state and both valid flags
`timescale 1ns / 1ps
`include "assert_macros.svh"

module velocity_pid_q2_14 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [vpid_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vpid_pkg::GAIN_W-1:0]           csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [vpid_pkg::FUNC_W-1:0]           req_func,
   input  logic signed [vpid_pkg::DATA_W-1:0]    req_measure,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vpid_pkg::DATA_W-1:0]    rsp_drive
);

   logic signed [vpid_pkg::GAIN_W-1:0] gain_prop_ff,  gain_prop_in;
   logic signed [vpid_pkg::GAIN_W-1:0] gain_integ_ff, gain_integ_in;
   logic signed [vpid_pkg::GAIN_W-1:0] gain_deriv_ff, gain_deriv_in;

   logic                               s1_valid_ff,   s1_valid_in;
   logic [vpid_pkg::FUNC_W-1:0]        s1_func_ff,    s1_func_in;
   logic signed [vpid_pkg::DATA_W-1:0] s1_measure_ff, s1_measure_in;

   logic signed [vpid_pkg::DATA_W-1:0] last_error_ff, last_error_in;
   logic signed [vpid_pkg::DATA_W-1:0] last_slope_ff, last_slope_in;
   logic signed [vpid_pkg::DATA_W-1:0] last_drive_ff, last_drive_in;

   logic                               rsp_valid_ff,  rsp_valid_in;
   logic signed [vpid_pkg::DATA_W-1:0] rsp_drive_ff,  rsp_drive_in;

   logic                               out_free;
   logic                               advance;
   logic                               load_s1;
   logic                               is_restart;
   vpid_pkg::terms_type                terms;
   logic signed [vpid_pkg::DATA_W-1:0] mac_drive;

   // gain register writes
   always_comb begin
      gain_prop_in  = gain_prop_ff;
      gain_integ_in = gain_integ_ff;
      gain_deriv_in = gain_deriv_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            vpid_pkg::CSR_GAIN_PROP:  gain_prop_in  = csr_wdata;
            vpid_pkg::CSR_GAIN_INTEG: gain_integ_in = csr_wdata;
            vpid_pkg::CSR_GAIN_DERIV: gain_deriv_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake between input register and result register
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign load_s1    = req_valid && !req_stall;
   assign is_restart = (s1_func_ff == vpid_pkg::FUNC_RESTART);

   // input register
   always_comb begin
      s1_valid_in   = load_s1 || (s1_valid_ff && !advance);
      s1_func_in    = load_s1 ? req_func    : s1_func_ff;
      s1_measure_in = load_s1 ? req_measure : s1_measure_ff;
   end

   vpid_diff u_diff (
      .func       (s1_func_ff),
      .measure    (s1_measure_ff),
      .last_error (last_error_ff),
      .last_slope (last_slope_ff),
      .terms      (terms)
   );

   vpid_mac u_mac (
      .gain_prop  (gain_prop_ff),
      .gain_integ (gain_integ_ff),
      .gain_deriv (gain_deriv_ff),
      .terms      (terms),
      .last_drive (last_drive_ff),
      .drive      (mac_drive)
   );

   // step state and result register update on each advancing transfer
   always_comb begin
      last_error_in = last_error_ff;
      last_slope_in = last_slope_ff;
      last_drive_in = last_drive_ff;
      rsp_drive_in  = rsp_drive_ff;
      if (advance) begin
         if (is_restart) begin
            last_error_in = terms.restart_error;
            last_slope_in = '0;
            last_drive_in = '0;
            rsp_drive_in  = '0;
         end else begin
            last_error_in = terms.error;
            last_slope_in = terms.slope;
            last_drive_in = mac_drive;
            rsp_drive_in  = mac_drive;
         end
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= '0;
         gain_integ_ff <= '0;
         gain_deriv_ff <= '0;
         s1_valid_ff   <= 1'b0;
         last_error_ff <= '0;
         last_slope_ff <= '0;
         last_drive_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gain_prop_ff  <= gain_prop_in;
         gain_integ_ff <= gain_integ_in;
         gain_deriv_ff <= gain_deriv_in;
         s1_valid_ff   <= s1_valid_in;
         last_error_ff <= last_error_in;
         last_slope_ff <= last_slope_in;
         last_drive_ff <= last_drive_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_func_ff    <= s1_func_in;
      s1_measure_ff <= s1_measure_in;
      rsp_drive_ff  <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   // checks on state and flow control
   `VPID_ASSERT_NEXT(a_restart_zero, advance && is_restart, rsp_drive_ff == '0 && last_slope_ff == '0 && last_drive_ff == '0, "restart did not clear drive and slope")
   `VPID_ASSERT_NEXT(a_drive_tracks, advance, last_drive_ff == rsp_drive_ff, "stored drive differs from presented result")
   `VPID_ASSERT_NOW(a_stall_when_full, s1_valid_ff && rsp_valid_ff && rsp_stall, req_stall, "input taken while both registers are held")
   `VPID_ASSERT_NEXT(a_state_holds, !advance, $stable(last_error_ff) && $stable(last_slope_ff), "step state changed without a transfer")

endmodule
